// File: design/bta_pkg.sv
// Shared constants, types and state encoding for the bakery ticket arbiter.
package bta_pkg;

   localparam int REQUESTERS  = 16;
   localparam int TICKET_BITS = 32;
   localparam int ID_BITS     = 4;
   localparam int IDX_BITS    = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
   // wide enough to compare an id against the requester count
   localparam int CMP_BITS    = ((ID_BITS > IDX_BITS) ? ID_BITS : IDX_BITS) + 1;

   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                load;
      logic                grant_valid;
      logic [ID_BITS-1:0]  grant_id;
      logic                ticket_saturated;
   } grant_type;

endpackage

// File: design/bakery_ticket_arbiter.sv
// Top level of the bakery ticket arbiter: sequencer plus result output register.
//
// Usage: each req_ item is a command from one requester. req_cmd low asks for
// the lock, high releases it; req_requester_id names the requester. A request
// from an idle requester draws a ticket one above the largest ever issued and
// marks it waiting; a release clears the mark. Each item yields exactly one
// rsp_ item: the waiting requester with the lowest ticket (lower id on a tie),
// rsp_grant_valid low with id zero when nobody waits, and rsp_ticket_saturated
// when this item's ticket reached the top value.
// Each item passes through the flag and ticket update, the grant scan that
// reads one ticket RAM entry per cycle, the compare and the result load.
// req_ready is high only while the sequencer is idle.
// A stalled receiver holds rsp_ in its output register; the next item is still
// accepted and scanned, and waits for the register to free before loading.
// Reset clears all waiting marks, the ticket high mark and the output valid;
// the ticket RAM needs no clearing since only waiting entries are compared.
module bakery_ticket_arbiter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic [bta_pkg::ID_BITS-1:0] req_requester_id,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_grant_valid,
   output logic [bta_pkg::ID_BITS-1:0] rsp_grant_id,
   output logic                        rsp_ticket_saturated
);

   bta_pkg::grant_type grant;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        grant_valid_ff;
   logic [bta_pkg::ID_BITS-1:0] grant_id_ff;
   logic                        sat_ff;
   logic                        rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   bta_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_requester_id (req_requester_id),
      .rsp_free         (rsp_free),
      .grant            (grant)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (grant.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grant.load) begin
         grant_valid_ff <= grant.grant_valid;
         grant_id_ff    <= grant.grant_id;
         sat_ff         <= grant.ticket_saturated;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_grant_valid      = grant_valid_ff;
   assign rsp_grant_id         = grant_id_ff;
   assign rsp_ticket_saturated = sat_ff;

endmodule

// File: design/bta_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bta_ctrl.sv
// Command sequencer: flag and ticket update, then a grant scan through the ticket RAM.
module bta_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic [bta_pkg::ID_BITS-1:0] req_requester_id,
   input  logic                        rsp_free,
   output bta_pkg::grant_type          grant
);

   localparam logic [bta_pkg::IDX_BITS-1:0] LAST_IDX =
      bta_pkg::IDX_BITS'(bta_pkg::REQUESTERS - 1);
   localparam logic [bta_pkg::TICKET_BITS-1:0] TICKET_TOP = '1;

   bta_pkg::state_type state_ff, state_in;

   logic [bta_pkg::REQUESTERS-1:0]  flags_ff, flags_in;
   logic [bta_pkg::TICKET_BITS-1:0] max_ff, max_in;
   logic                            sat_ff, sat_in;
   logic [bta_pkg::IDX_BITS-1:0]    cnt_ff, cnt_in;
   logic                            issue_ff, issue_in;
   logic                            chk_ff, chk_in;
   logic [bta_pkg::IDX_BITS-1:0]    chk_idx_ff, chk_idx_in;
   logic                            best_v_ff, best_v_in;
   logic [bta_pkg::TICKET_BITS-1:0] best_t_ff, best_t_in;
   logic [bta_pkg::IDX_BITS-1:0]    best_i_ff, best_i_in;

   logic                            accept;
   logic                            id_ok;
   logic [bta_pkg::IDX_BITS-1:0]    idx;
   logic [bta_pkg::TICKET_BITS-1:0] new_ticket;
   logic                            wr_en;
   logic [bta_pkg::TICKET_BITS-1:0] rd_data;
   logic                            hit;

   assign req_ready = (state_ff == bta_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign id_ok     = bta_pkg::CMP_BITS'(req_requester_id)
                      < bta_pkg::CMP_BITS'(bta_pkg::REQUESTERS);
   assign idx       = bta_pkg::IDX_BITS'(req_requester_id);
   // max_ff tracks the largest ticket ever issued; tickets never shrink
   assign new_ticket = (max_ff == TICKET_TOP) ? TICKET_TOP : max_ff + 1'b1;
   assign wr_en      = accept && id_ok && (req_cmd == bta_pkg::CMD_REQUEST)
                       && !flags_ff[idx];
   assign hit        = chk_ff && flags_ff[chk_idx_ff]
                       && (!best_v_ff || (rd_data < best_t_ff));

   bta_ram #(
      .WIDTH (bta_pkg::TICKET_BITS),
      .DEPTH (bta_pkg::REQUESTERS)
   ) u_tickets (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx),
      .wr_data (new_ticket),
      .rd_en   (issue_ff),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bta_pkg::ST_IDLE;
         flags_ff <= '0;
         max_ff   <= '0;
         issue_ff <= 1'b0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         flags_ff <= flags_in;
         max_ff   <= max_in;
         issue_ff <= issue_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff     <= sat_in;
      cnt_ff     <= cnt_in;
      chk_idx_ff <= chk_idx_in;
      best_v_ff  <= best_v_in;
      best_t_ff  <= best_t_in;
      best_i_ff  <= best_i_in;
   end

   always_comb begin
      state_in   = state_ff;
      flags_in   = flags_ff;
      max_in     = max_ff;
      sat_in     = sat_ff;
      cnt_in     = cnt_ff;
      issue_in   = issue_ff;
      chk_in     = issue_ff;
      chk_idx_in = cnt_ff;
      best_v_in  = best_v_ff;
      best_t_in  = best_t_ff;
      best_i_in  = best_i_ff;
      grant      = '0;

      case (state_ff)
         bta_pkg::ST_IDLE: begin
            if (accept) begin
               sat_in    = 1'b0;
               cnt_in    = '0;
               issue_in  = 1'b1;
               best_v_in = 1'b0;
               best_t_in = '0;
               best_i_in = '0;
               state_in  = bta_pkg::ST_SCAN;
               if (wr_en) begin
                  flags_in[idx] = 1'b1;
                  max_in        = new_ticket;
                  sat_in        = (new_ticket == TICKET_TOP);
               end else if (id_ok && (req_cmd == bta_pkg::CMD_RELEASE)) begin
                  flags_in[idx] = 1'b0;
               end
            end
         end
         bta_pkg::ST_SCAN: begin
            // advance the read address; stop issuing after the last entry
            if (issue_ff) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end
            end
            if (hit) begin
               best_v_in = 1'b1;
               best_t_in = rd_data;
               best_i_in = chk_idx_ff;
            end
            if (chk_ff && (chk_idx_ff == LAST_IDX)) begin
               state_in = bta_pkg::ST_DONE;
            end
         end
         bta_pkg::ST_DONE: begin
            // hold the result until the output register is free
            if (rsp_free) begin
               grant.load             = 1'b1;
               grant.grant_valid      = best_v_ff;
               grant.grant_id         = bta_pkg::ID_BITS'(best_i_ff);
               grant.ticket_saturated = sat_ff;
               state_in               = bta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bta_pkg::ST_IDLE;
         end
      endcase
   end

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> state_ff == bta_pkg::ST_SCAN)
      else $error("ticket read issued outside scan");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == bta_pkg::ST_SCAN) && issue_ff && (cnt_ff == '0))
      else $error("accepted item did not start a scan");

   a_grant_flagged: assert property (@(posedge clock) disable iff (reset)
      grant.load && grant.grant_valid |-> flags_ff[best_i_ff])
      else $error("granted requester is not waiting");

   a_no_grant_when_idle: assert property (@(posedge clock) disable iff (reset)
      grant.load && (flags_ff == '0) |-> !grant.grant_valid && (grant.grant_id == '0))
      else $error("grant reported with no waiting requester");

   a_load_ends_item: assert property (@(posedge clock) disable iff (reset)
      grant.load |=> state_ff == bta_pkg::ST_IDLE)
      else $error("result loaded without returning to idle");

endmodule

// File: verif/testbench.sv
// Testbench for the bakery ticket arbiter: directed table, random traffic and a grant predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_COUNT   = 24;
   localparam int RANDOM_ITEMS     = 1030;
   localparam int QUIET_ITEMS      = 150;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int DRAIN_CYCLES     = 40;
   localparam int REPORT_LIMIT     = 10;

   localparam logic [bta_pkg::TICKET_BITS-1:0] TICKET_TOP = '1;

   typedef struct packed {
      logic                        grant_valid;
      logic [bta_pkg::ID_BITS-1:0] grant_id;
      logic                        ticket_saturated;
   } grant_result_type;

   typedef struct packed {
      logic                        cmd;
      logic [bta_pkg::ID_BITS-1:0] id;
      logic                        has_literal;
      grant_result_type            result;
   } directed_row_type;

   localparam grant_result_type NO_GRANT = '{1'b0, 4'd0, 1'b0};

   // Tickets only grow, so the literal rows follow from a fresh reset.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{bta_pkg::CMD_RELEASE, 4'd0,  1'b1, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd15, 1'b1, NO_GRANT},
      '{bta_pkg::CMD_REQUEST, 4'd15, 1'b1, '{1'b1, 4'd15, 1'b0}},
      '{bta_pkg::CMD_REQUEST, 4'd0,  1'b1, '{1'b1, 4'd15, 1'b0}},
      '{bta_pkg::CMD_REQUEST, 4'd15, 1'b0, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd15, 1'b0, NO_GRANT},
      '{bta_pkg::CMD_REQUEST, 4'd15, 1'b0, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd0,  1'b0, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd15, 1'b1, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd15, 1'b1, NO_GRANT},
      '{bta_pkg::CMD_REQUEST, 4'd10, 1'b0, NO_GRANT},
      '{bta_pkg::CMD_REQUEST, 4'd5,  1'b0, NO_GRANT},
      '{bta_pkg::CMD_REQUEST, 4'd3,  1'b0, NO_GRANT},
      '{bta_pkg::CMD_REQUEST, 4'd12, 1'b0, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd3,  1'b0, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd10, 1'b0, NO_GRANT},
      '{bta_pkg::CMD_REQUEST, 4'd3,  1'b0, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd5,  1'b0, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd12, 1'b0, NO_GRANT},
      '{bta_pkg::CMD_REQUEST, 4'd0,  1'b0, NO_GRANT},
      '{bta_pkg::CMD_REQUEST, 4'd15, 1'b0, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd3,  1'b0, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd0,  1'b0, NO_GRANT},
      '{bta_pkg::CMD_RELEASE, 4'd15, 1'b1, NO_GRANT}
   };

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_cmd;
   logic [bta_pkg::ID_BITS-1:0] req_requester_id;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic                        rsp_grant_valid;
   logic [bta_pkg::ID_BITS-1:0] rsp_grant_id;
   logic                        rsp_ticket_saturated;

   // predictor state
   logic [bta_pkg::REQUESTERS-1:0]  waiting_mask;
   logic [bta_pkg::TICKET_BITS-1:0] ticket_book [bta_pkg::REQUESTERS];
   grant_result_type                pending_grants [$];
   grant_result_type                last_grant;

   int grant_mismatches;
   bit quiet_phase;
   bit long_hold_due;

   bakery_ticket_arbiter i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_requester_id     (req_requester_id),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_grant_valid      (rsp_grant_valid),
      .rsp_grant_id         (rsp_grant_id),
      .rsp_ticket_saturated (rsp_ticket_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("bakery_ticket_arbiter verification failed");
      $finish;
   end

   // Apply one command to the predicted lock state and return the grant after it.
   function automatic grant_result_type advance_bakery(
      input logic                        cmd,
      input logic [bta_pkg::ID_BITS-1:0] id);
      grant_result_type                grant;
      logic [bta_pkg::TICKET_BITS-1:0] high_mark;
      logic [bta_pkg::TICKET_BITS-1:0] lowest;
      grant     = NO_GRANT;
      high_mark = '0;
      lowest    = '0;
      if (int'(id) < bta_pkg::REQUESTERS) begin
         if (cmd == bta_pkg::CMD_REQUEST) begin
            if (!waiting_mask[id]) begin
               // scan every ticket, released ones included
               for (int j = 0; j < bta_pkg::REQUESTERS; j++) begin
                  if (ticket_book[j] > high_mark) high_mark = ticket_book[j];
               end
               if (high_mark != TICKET_TOP) high_mark = high_mark + 1'b1;
               grant.ticket_saturated = (high_mark == TICKET_TOP);
               ticket_book[id]  = high_mark;
               waiting_mask[id] = 1'b1;
            end
         end else begin
            waiting_mask[id] = 1'b0;
         end
      end
      for (int j = 0; j < bta_pkg::REQUESTERS; j++) begin
         if (waiting_mask[j] && (!grant.grant_valid || ticket_book[j] < lowest)) begin
            grant.grant_valid = 1'b1;
            grant.grant_id    = bta_pkg::ID_BITS'(j);
            lowest            = ticket_book[j];
         end
      end
      return grant;
   endfunction

   // Hold the item on the port until it is taken.
   task automatic offer_item(input logic cmd, input logic [bta_pkg::ID_BITS-1:0] id);
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_requester_id <= id;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_sender();
      int gap;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      logic                        cmd;
      logic [bta_pkg::ID_BITS-1:0] id;
      int                          effective_count;
      int                          pick;
      bit                          paused;
      grant_result_type            predicted;
      waiting_mask     = '0;
      foreach (ticket_book[j]) ticket_book[j] = '0;
      last_grant       = NO_GRANT;
      grant_mismatches = 0;
      quiet_phase      = 1'b0;
      long_hold_due    = 1'b0;
      effective_count  = 0;
      paused           = 1'b0;
      req_valid        <= 1'b0;
      req_cmd          <= bta_pkg::CMD_REQUEST;
      req_requester_id <= '0;
      reset            <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         offer_item(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].id);
         predicted = advance_bakery(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].id);
         pending_grants.push_back(DIRECTED_ROWS[r].has_literal ? DIRECTED_ROWS[r].result
                                                               : predicted);
         last_grant = predicted;
         idle_sender();
      end

      // Mostly well-formed traffic: the holder hands the lock back, others take a
      // ticket or drop out; a few items are random noise.
      while (effective_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         id   = bta_pkg::ID_BITS'($urandom_range(0, (1 << bta_pkg::ID_BITS) - 1));
         if (pick < 8) begin
            cmd = 1'($urandom_range(0, 1));
         end else if (pick < 40 && last_grant.grant_valid) begin
            cmd = bta_pkg::CMD_RELEASE;
            id  = last_grant.grant_id;
         end else begin
            cmd = waiting_mask[id] ? bta_pkg::CMD_RELEASE : bta_pkg::CMD_REQUEST;
         end
         if ((cmd == bta_pkg::CMD_REQUEST) != waiting_mask[id]) effective_count++;
         offer_item(cmd, id);
         last_grant = advance_bakery(cmd, id);
         pending_grants.push_back(last_grant);
         if (effective_count == 300) long_hold_due = 1'b1;
         quiet_phase = (effective_count >= RANDOM_ITEMS - QUIET_ITEMS);
         if (effective_count == 600 && !paused) begin
            // drain the block before going on
            paused = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_grants.size() != 0);
         end else begin
            idle_sender();
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_grants.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (grant_mismatches == 0 && pending_grants.size() == 0) begin
         $display("bakery_ticket_arbiter verification clean");
      end else begin
         $display("bakery_ticket_arbiter verification failed");
      end
      $finish;
   end

   initial begin : result_sink
      int stall_left;
      bit long_hold_done;
      stall_left     = 0;
      long_hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_due && !long_hold_done) begin
            // stall long enough that the block backs up into its input
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && !quiet_phase && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      grant_result_type seen;
      grant_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.grant_valid      = rsp_grant_valid;
         seen.grant_id         = rsp_grant_id;
         seen.ticket_saturated = rsp_ticket_saturated;
         if (pending_grants.size() == 0) begin
            grant_mismatches++;
            if (grant_mismatches <= REPORT_LIMIT)
               $display("%0t: grant item with none expected: valid=%0b id=%0d sat=%0b",
                        $time, seen.grant_valid, seen.grant_id, seen.ticket_saturated);
         end else begin
            want = pending_grants.pop_front();
            if (seen.grant_valid !== want.grant_valid || seen.grant_id !== want.grant_id ||
                seen.ticket_saturated !== want.ticket_saturated) begin
               grant_mismatches++;
               if (grant_mismatches <= REPORT_LIMIT)
                  $display("%0t: grant mismatch: expected valid=%0b id=%0d sat=%0b, %s",
                           $time, want.grant_valid, want.grant_id, want.ticket_saturated,
                           $sformatf("got valid=%0b id=%0d sat=%0b", seen.grant_valid,
                                     seen.grant_id, seen.ticket_saturated));
            end
         end
      end
   end

endmodule
